// ===== src/tab_to_space_expander_defines.svh =====
// Assertion macros for the tab expander RTL (used by the item queue).
`ifndef TAB_TO_SPACE_EXPANDER_DEFINES_SVH
`define TAB_TO_SPACE_EXPANDER_DEFINES_SVH
`ifndef SYNTHESIS
`define TTE_ASSERT_ON(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tte assertion failed");
`define TTE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("tte forbidden condition");
`else
`define TTE_ASSERT_ON(label, clk, rst, prop)
`define TTE_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/tte_pkg.sv =====
// Shared types and constants of the tab expander.
`timescale 1ns / 1ps
package tte_pkg;
   localparam int unsigned STOP_MAP_BITS = 64;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [6:0] WIDTH_CAP = 7'd64;
   localparam logic [15:0] COL_MAX = 16'hFFFF;

   localparam logic [1:0] CSR_REPEAT_WIDTH = 2'd0;
   localparam logic [1:0] CSR_STOP_MAP = 2'd1;
   localparam logic [1:0] CSR_LAST_STOP = 2'd2;

   // one queued item: byte to send and how many times (1..64)
   typedef struct packed {
      logic [7:0] byte_val;
      logic [6:0] count;
   } entry_type;
endpackage

// ===== src/tte_front.sv =====
// Front end: accepts bytes, tracks the column and works out each tab's run length.
`timescale 1ns / 1ps
module tte_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_write_data,
   input  logic                 q_full,
   output logic                 q_push,
   output tte_pkg::entry_type   q_entry
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [15:0] column_ff, column_in;
   logic [6:0]  rem_ff, rem_in;
   logic [3:0]  bit_ff, bit_in;
   logic [5:0]  scan_ff, scan_in;
   logic [6:0]  n_ff, n_in;
   logic [6:0]  repeat_width_ff;
   logic [63:0] stop_map_ff;
   logic [5:0]  last_stop_ff;

   logic [6:0]  w_cap;
   logic [7:0]  rem_shift, rem_sub;
   logic        stop_hit;
   logic        accept;

   function automatic logic [15:0] sat_add(input logic [15:0] col, input logic [6:0] n);
      logic [16:0] s;
      s = {1'b0, col} + {10'd0, n};
      return s[16] ? tte_pkg::COL_MAX : s[15:0];
   endfunction

   assign w_cap = (repeat_width_ff > tte_pkg::WIDTH_CAP) ? tte_pkg::WIDTH_CAP
                                                         : repeat_width_ff;
   assign req_ready = (state_ff == S_IDLE) && !q_full;
   assign accept = req_valid && req_ready;

   assign rem_shift = {rem_ff, column_ff[bit_ff]};
   assign rem_sub = (rem_shift >= {1'b0, w_cap}) ? (rem_shift - {1'b0, w_cap}) : rem_shift;
   assign stop_hit = (scan_ff == last_stop_ff) ||
                     (({1'b0, scan_ff} < 7'(tte_pkg::STOP_MAP_BITS)) && stop_map_ff[scan_ff]);

   always_comb begin
      state_in = state_ff;
      column_in = column_ff;
      rem_in = rem_ff;
      bit_in = bit_ff;
      scan_in = scan_ff;
      n_in = n_ff;
      q_push = 1'b0;
      q_entry.byte_val = tte_pkg::CH_SPACE;
      q_entry.count = n_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_in_byte != tte_pkg::CH_TAB) begin
                  q_push = 1'b1;
                  q_entry.byte_val = req_in_byte;
                  q_entry.count = 7'd1;
                  if (req_in_byte == tte_pkg::CH_BS) begin
                     if (column_ff > 16'd1) column_in = column_ff - 16'd1;
                  end else if (req_in_byte == tte_pkg::CH_CR ||
                               req_in_byte == tte_pkg::CH_LF) begin
                     column_in = 16'd1;
                  end else begin
                     column_in = sat_add(column_ff, 7'd1);
                  end
               end else if (repeat_width_ff != 7'd0) begin
                  state_in = S_DIV;
                  rem_in = 7'd0;
                  bit_in = 4'd15;
               end else if (column_ff >= {10'd0, last_stop_ff}) begin
                  q_push = 1'b1;
                  q_entry.count = 7'd1;
                  column_in = sat_add(column_ff, 7'd1);
               end else begin
                  state_in = S_SCAN;
                  scan_in = column_ff[5:0] + 6'd1;
               end
            end
         end
         S_DIV: begin
            rem_in = rem_sub[6:0];
            if (bit_ff == 4'd0) begin
               n_in = (rem_sub == 8'd0) ? 7'd1 : (w_cap - rem_sub[6:0] + 7'd1);
               state_in = S_PUSH;
            end else begin
               bit_in = bit_ff - 4'd1;
            end
         end
         S_SCAN: begin
            if (stop_hit) begin
               n_in = {1'b0, scan_ff} - {1'b0, column_ff[5:0]} + 7'd1;
               state_in = S_PUSH;
            end else begin
               scan_in = scan_ff + 6'd1;
            end
         end
         S_PUSH: begin
            if (!q_full) begin
               q_push = 1'b1;
               column_in = sat_add(column_ff, n_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         column_ff <= 16'd1;
         repeat_width_ff <= 7'd8;
         stop_map_ff <= 64'd0;
         last_stop_ff <= 6'd0;
      end else begin
         state_ff <= state_in;
         column_ff <= column_in;
         if (csr_write_enable) begin
            if (csr_index == tte_pkg::CSR_REPEAT_WIDTH) repeat_width_ff <= csr_write_data[6:0];
            if (csr_index == tte_pkg::CSR_STOP_MAP) stop_map_ff <= csr_write_data;
            if (csr_index == tte_pkg::CSR_LAST_STOP) last_stop_ff <= csr_write_data[5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      bit_ff <= bit_in;
      scan_ff <= scan_in;
      n_ff <= n_in;
   end
endmodule

// ===== src/tte_queue.sv =====
// Small item queue between the front end and the emitter.
`timescale 1ns / 1ps
`include "tab_to_space_expander_defines.svh"
module tte_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tte_pkg::entry_type   push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output tte_pkg::entry_type   head_entry
);
   tte_pkg::entry_type mem_ff [tte_pkg::QUEUE_DEPTH];
   logic [tte_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tte_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tte_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [tte_pkg::QPTR_W-1:0] PTR_LAST = tte_pkg::QPTR_W'(tte_pkg::QUEUE_DEPTH - 1);
   localparam logic [tte_pkg::QCNT_W-1:0] CNT_FULL = tte_pkg::QCNT_W'(tte_pkg::QUEUE_DEPTH);

   assign full = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop) rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

   `TTE_ASSERT_NEVER(a_q_overflow, clock, reset, push && full && !pop)
   `TTE_ASSERT_NEVER(a_q_underflow, clock, reset, pop && !head_valid)
   `TTE_ASSERT_ON(a_q_empty_ptrs, clock, reset, (count_ff == '0) |-> (rd_ptr_ff == wr_ptr_ff))
endmodule

// ===== src/tte_back.sv =====
// Emitter: repeats each queued byte its count of times into the output register.
`timescale 1ns / 1ps
module tte_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  tte_pkg::entry_type   head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last
);
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic [5:0] emit_cnt_ff, emit_cnt_in;
   logic       load;
   logic       is_last;

   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last = (({1'b0, emit_cnt_ff} + 7'd1) == head_entry.count);
   assign pop = load && is_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      emit_cnt_in = emit_cnt_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         emit_cnt_in = is_last ? 6'd0 : emit_cnt_ff + 6'd1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         emit_cnt_ff <= 6'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_byte_ff <= head_entry.byte_val;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last = rsp_last_ff;
endmodule

// ===== src/tab_to_space_expander.sv =====
// Top level of the tab expander: front end, item queue and emitter.
// Path: a plain byte passes the item queue and the output register before it is on rsp_; a
//   tab's run length comes from a 16-step column remainder, a stop scan, or is one space.
// Throughput: one plain byte per cycle while the queue has room; a tab holds the input while
//   its run length is worked out; spaces leave one per cycle while rsp_ready is high.
// Reset: synchronous, active high; column 1, width 8, no stops, queue empty.
`timescale 1ns / 1ps
module tab_to_space_expander (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);
   logic               q_full;
   logic               q_push;
   tte_pkg::entry_type q_entry;
   logic               q_pop;
   logic               q_head_valid;
   tte_pkg::entry_type q_head;

   tte_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   tte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head)
   );

   tte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (q_head_valid),
      .head_entry   (q_head),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );
endmodule
